/* design/snp_pkg.sv */
// Package for the scale notification parser.
// Holds the parse phase type, frame constants and the result word type.
// No dependencies.
package snp_pkg;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_TOPIC   = 6'b000010,
        PH_LENGTH  = 6'b000100,
        PH_TYPE    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    localparam logic [7:0] HDR_LEAD    = 8'hEF;
    localparam logic [7:0] HDR_SECOND  = 8'hDD;
    localparam logic [7:0] TOPIC_BATT  = 8'h08;
    localparam logic [7:0] TOPIC_WGT   = 8'h0C;
    localparam logic [7:0] TYPE_WGT    = 8'h05;
    localparam logic [7:0] SIGN_MASK   = 8'h02;
    localparam logic [7:0] WGT_MIN_LEN = 8'd6;
    localparam logic [7:0] UNIT_MIN    = 8'd1;
    localparam logic [7:0] UNIT_MAX    = 8'd4;

    // Payload byte positions inside a weight frame.
    localparam logic [2:0] OFS_LOW  = 3'd0;
    localparam logic [2:0] OFS_HIGH = 3'd1;
    localparam logic [2:0] OFS_UNIT = 3'd4;
    localparam logic [2:0] OFS_SIGN = 3'd5;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_BATTERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] magnitude;
        logic [2:0]  decimals;
        logic        negative;
        logic [6:0]  battery;
    } result_t;

endpackage

/* design/snp_parser.sv */
// Frame parser state for the scale notification parser.
// Holds the header hunt, frame fields and the last decoded reports; uses snp_pkg.
module snp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic                buffer_start,
    output logic                emit,
    output snp_pkg::result_t    result
);
    import snp_pkg::*;

    phase_t      phase_reg, phase_next, phase_eff;
    logic        lead_reg, lead_next, lead_eff;
    logic [2:0]  offset_reg, offset_next;
    logic [7:0]  topic_reg, topic_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  raw_low_reg, raw_low_next;
    logic [7:0]  raw_high_reg, raw_high_next;
    logic [7:0]  unit_reg, unit_next;
    result_t     held_reg, held_next;

    // A buffer start restarts the hunt before this byte is looked at.
    assign phase_eff = buffer_start ? PH_HUNT : phase_reg;
    assign lead_eff  = buffer_start ? 1'b0 : lead_reg;

    always_comb begin
        phase_next    = phase_eff;
        lead_next     = lead_eff;
        offset_next   = offset_reg;
        topic_next    = topic_reg;
        length_next   = length_reg;
        raw_low_next  = raw_low_reg;
        raw_high_next = raw_high_reg;
        unit_next     = unit_reg;
        held_next     = held_reg;
        emit          = 1'b0;
        case (phase_eff)
            PH_HUNT: begin
                if (rx_byte == 8'd0) begin
                    phase_next = PH_DONE;
                    lead_next  = 1'b0;
                end else if (lead_eff && rx_byte == HDR_SECOND) begin
                    phase_next = PH_TOPIC;
                    lead_next  = 1'b0;
                end else begin
                    lead_next = (rx_byte == HDR_LEAD);
                end
            end
            PH_TOPIC: begin
                topic_next = rx_byte;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                length_next = rx_byte;
                phase_next  = PH_TYPE;
            end
            PH_TYPE: begin
                if (topic_reg == TOPIC_BATT) begin
                    held_next.battery = rx_byte[6:0];
                    held_next.kind    = KIND_BATTERY;
                    phase_next        = PH_DONE;
                    emit              = 1'b1;
                end else if (topic_reg == TOPIC_WGT && rx_byte == TYPE_WGT
                             && length_reg >= WGT_MIN_LEN) begin
                    phase_next  = PH_PAYLOAD;
                    offset_next = OFS_LOW;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_PAYLOAD: begin
                offset_next = offset_reg + 3'd1;
                if (offset_reg == OFS_LOW) begin
                    raw_low_next = rx_byte;
                end
                if (offset_reg == OFS_HIGH) begin
                    raw_high_next = rx_byte;
                end
                if (offset_reg == OFS_UNIT) begin
                    unit_next = rx_byte;
                end
                if (offset_reg == OFS_SIGN) begin
                    held_next.magnitude = {raw_high_reg, raw_low_reg};
                    held_next.decimals  = (unit_reg >= UNIT_MIN && unit_reg <= UNIT_MAX)
                                          ? unit_reg[2:0] : 3'd0;
                    held_next.negative  = (rx_byte & SIGN_MASK) != 8'd0;
                    held_next.kind      = KIND_WEIGHT;
                    phase_next          = PH_DONE;
                    offset_next         = OFS_LOW;
                    emit                = 1'b1;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign result = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            lead_reg     <= 1'b0;
            offset_reg   <= 3'd0;
            topic_reg    <= 8'd0;
            length_reg   <= 8'd0;
            raw_low_reg  <= 8'd0;
            raw_high_reg <= 8'd0;
            unit_reg     <= 8'd0;
            held_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            lead_reg     <= lead_next;
            offset_reg   <= offset_next;
            topic_reg    <= topic_next;
            length_reg   <= length_next;
            raw_low_reg  <= raw_low_next;
            raw_high_reg <= raw_high_next;
            unit_reg     <= unit_next;
            held_reg     <= held_next;
        end
    end

endmodule

/* design/scale_notification_parser.sv */
// Top level of the scale notification parser: input register, parser, result register.
// Uses snp_pkg and snp_parser.
//
// Takes one notification byte per cycle while no finished report waits on a stalled
// result register. Each byte goes into an input register and is parsed there
// combinationally; a report, if the byte completes one, is written into the result
// register as the input register advances. The input register advances whenever the
// result register is free or the byte completes no report, so with m_ready held high
// the block takes a word on every clock.
module scale_notification_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_buffer_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [15:0] m_weight_magnitude,
    output logic [2:0]  m_weight_decimals,
    output logic        m_weight_negative,
    output logic [6:0]  m_battery_level
);
    import snp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       emit;
    logic       advance;
    logic       out_free;
    result_t    result;

    snp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_byte      (in_byte_reg),
        .buffer_start (in_start_reg),
        .emit         (emit),
        .result       (result)
    );

    assign out_free = !out_valid_reg || m_ready;
    // A word that completes no report never waits on the result side.
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_buffer_start;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_result_kind      = out_reg.kind;
    assign m_weight_magnitude = out_reg.magnitude;
    assign m_weight_decimals  = out_reg.decimals;
    assign m_weight_negative  = out_reg.negative;
    assign m_battery_level    = out_reg.battery;

endmodule

/* design/snp_checker.sv */
// Port-level checks for the scale notification parser.
// Sees only the top-level ports; bound to scale_notification_parser below.
module snp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [15:0] m_weight_magnitude,
    input logic [2:0]  m_weight_decimals,
    input logic        m_weight_negative,
    input logic [6:0]  m_battery_level
);

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid
        && $stable(m_result_kind) && $stable(m_weight_magnitude)
        && $stable(m_weight_decimals) && $stable(m_weight_negative)
        && $stable(m_battery_level))
        else $error("result word changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A nonzero decimal count only ever comes from a unit code of one to four.
    a_decimals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_weight_decimals <= 3'd4)
        else $error("decimal count out of range");

    // With the result side free, the input side is never held off.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register is empty");

endmodule

bind scale_notification_parser snp_checker u_snp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_result_kind      (m_result_kind),
    .m_weight_magnitude (m_weight_magnitude),
    .m_weight_decimals  (m_weight_decimals),
    .m_weight_negative  (m_weight_negative),
    .m_battery_level    (m_battery_level)
);
